// File: sv/led_marquee_scroll_rotate_assert.svh
// ---------------------------------------------------------------------------
// LED marquee assertion macros
// Shared concurrent assertion forms for the marquee block.
// ---------------------------------------------------------------------------
`ifndef LED_MARQUEE_SCROLL_ROTATE_ASSERT_SVH
`define LED_MARQUEE_SCROLL_ROTATE_ASSERT_SVH

// same-cycle implication under asynchronous reset
`define LMSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under asynchronous reset
`define LMSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lmsr_pkg.sv
// ---------------------------------------------------------------------------
// LED marquee package
// Geometry, timing constants, mode codes and the message table.
// ---------------------------------------------------------------------------
package lmsr_pkg;

    localparam int DISPLAY_COLUMNS  = 32;
    localparam int MESSAGE_COLUMNS  = 64;   // power of two: offsets wrap by truncation
    localparam int FRAME_BASE_TICKS = 1000;

    localparam int COL_W  = $clog2(DISPLAY_COLUMNS);
    localparam int MSG_W  = $clog2(MESSAGE_COLUMNS);
    localparam int TICK_W = $clog2(FRAME_BASE_TICKS);
    localparam int ROT_W  = 3;

    localparam logic [TICK_W-1:0] FRAME_BASE = TICK_W'(FRAME_BASE_TICKS);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(DISPLAY_COLUMNS - 1);
    localparam logic [MSG_W-1:0]  LAST_MSG   = MSG_W'(MESSAGE_COLUMNS - 1);

    localparam logic [7:0] SPEED_RESET = 8'd127;

    // scroll modes
    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_HORIZ = 2'd1;
    localparam logic [1:0] MODE_VERT  = 2'd2;

    typedef logic [7:0] pattern_t;

    localparam pattern_t MESSAGE_ROM [64] = '{
        8'd0, 8'd66, 8'd36, 8'd24, 8'd24, 8'd36, 8'd66, 8'd0,
        8'd0, 8'd96, 8'd24, 8'd6,  8'd6,  8'd24, 8'd96, 8'd0,
        8'd0, 8'd60, 8'd66, 8'd66, 8'd66, 8'd66, 8'd60, 8'd0,
        8'd0, 8'd126, 8'd24, 8'd36, 8'd36, 8'd66, 8'd66, 8'd0,
        8'd0, 8'd0, 8'd126, 8'd32, 8'd64, 8'd64, 8'd64, 8'd0,
        8'd0, 8'd78, 8'd74, 8'd74, 8'd74, 8'd74, 8'd126, 8'd0,
        8'd0, 8'd60, 8'd66, 8'd66, 8'd66, 8'd66, 8'd60, 8'd0,
        8'd0, 8'd60, 8'd66, 8'd66, 8'd66, 8'd66, 8'd60, 8'd0
    };

    function automatic pattern_t rot_right8(input pattern_t v, input logic [ROT_W-1:0] n);
        logic [15:0] w;
        begin
            w = {v, v} >> n;
            return w[7:0];
        end
    endfunction

endpackage

// File: sv/led_marquee_scroll_rotate.sv
// ---------------------------------------------------------------------------
// LED marquee scroll/rotate
// Tick-driven scrolling marquee: frame timing, offsets and column output.
// ---------------------------------------------------------------------------
// Flow: an accepted frame-boundary tick sets the state register to emit; then
//   one column per cycle passes the output register while m_tready is high (32
//   columns per frame). A non-boundary tick leaves s_tready high; a boundary
//   tick holds it low until every column has passed the shared ROM/rotator.
// Reset (rst_n low, async): idle, init mode, offsets and tick count zero,
//   scroll speed 127, no column pending.
module led_marquee_scroll_rotate
(
    input  logic        clk,
    input  logic        rst_n,
    // tick input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] init_button, [1] horizontal_button,
                                    // [2] vertical_button, [7:3] zero
    // column output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [4:0] column_index, [12:5] column_pattern,
                                    // [15:13] zero
    output logic        m_tlast,    // frame_end
    // scroll speed register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam int COL_W  = lmsr_pkg::COL_W;
    localparam int MSG_W  = lmsr_pkg::MSG_W;
    localparam int TICK_W = lmsr_pkg::TICK_W;
    localparam int ROT_W  = lmsr_pkg::ROT_W;

    logic                   state_reg, state_next;
    logic [1:0]             mode_reg, mode_next;
    logic [MSG_W-1:0]       hoff_reg, hoff_next;
    logic [ROT_W-1:0]       voff_reg, voff_next;
    logic [TICK_W-1:0]      count_reg, count_next;
    logic [7:0]             speed_reg, speed_next;
    logic [COL_W-1:0]       col_reg, col_next;

    logic                   out_valid_reg, out_valid_next;
    logic [COL_W-1:0]       out_col_reg, out_col_next;
    lmsr_pkg::pattern_t     out_pat_reg, out_pat_next;
    logic                   out_last_reg, out_last_next;

    logic                   in_accept;
    logic                   load;
    logic                   boundary;
    logic [1:0]             mode_upd;
    logic [TICK_W-1:0]      sub;
    logic [TICK_W-1:0]      period;
    logic [TICK_W:0]        tick_next;
    logic [MSG_W-1:0]       pos;
    lmsr_pkg::pattern_t     pattern;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_pat_reg, out_col_reg};

    // output register frees up: the shared column unit may run this cycle
    assign load = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    // the shared column unit: message lookup followed by bit rotation
    assign pos     = hoff_reg + MSG_W'(col_reg);
    assign pattern = lmsr_pkg::rot_right8(lmsr_pkg::MESSAGE_ROM[pos], voff_reg);

    always_comb
    begin
        // mode priority: init over horizontal over vertical, else hold
        if (s_tdata[0])
            mode_upd = lmsr_pkg::MODE_INIT;
        else if (s_tdata[1])
            mode_upd = lmsr_pkg::MODE_HORIZ;
        else if (s_tdata[2])
            mode_upd = lmsr_pkg::MODE_VERT;
        else
            mode_upd = mode_reg;

        // frame period, saturating at one tick
        sub = {speed_reg, 2'b00};
        if (sub >= lmsr_pkg::FRAME_BASE)
            period = TICK_W'(1);
        else
            period = lmsr_pkg::FRAME_BASE - sub;

        tick_next = {1'b0, count_reg} + (TICK_W+1)'(1);
        boundary  = (tick_next >= {1'b0, period});
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        hoff_next      = hoff_reg;
        voff_next      = voff_reg;
        count_next     = count_reg;
        speed_next     = speed_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        out_col_next   = out_col_reg;
        out_pat_next   = out_pat_reg;
        out_last_next  = out_last_reg;

        if (cfg_valid && cfg_ready)
            speed_next = cfg_data;

        if (m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next = mode_upd;
                    if (!boundary)
                        count_next = tick_next[TICK_W-1:0];
                    else
                    begin
                        count_next = '0;
                        col_next   = '0;
                        state_next = ST_EMIT;
                        case (mode_upd)
                            lmsr_pkg::MODE_INIT:
                            begin
                                hoff_next = '0;
                                voff_next = '0;
                            end
                            lmsr_pkg::MODE_HORIZ:
                                hoff_next = (hoff_reg == lmsr_pkg::LAST_MSG) ? '0
                                                                             : hoff_reg + 1'b1;
                            lmsr_pkg::MODE_VERT:
                                voff_next = voff_reg + 1'b1;
                            default:
                            begin
                                hoff_next = hoff_reg;
                                voff_next = voff_reg;
                            end
                        endcase
                    end
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = col_reg;
                    out_pat_next   = pattern;
                    out_last_next  = (col_reg == lmsr_pkg::LAST_COL);
                    col_next       = col_reg + 1'b1;
                    if (col_reg == lmsr_pkg::LAST_COL)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= lmsr_pkg::MODE_INIT;
            hoff_reg      <= '0;
            voff_reg      <= '0;
            count_reg     <= '0;
            speed_reg     <= lmsr_pkg::SPEED_RESET;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            hoff_reg      <= hoff_next;
            voff_reg      <= voff_next;
            count_reg     <= count_next;
            speed_reg     <= speed_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // column payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_col_reg  <= out_col_next;
        out_pat_reg  <= out_pat_next;
        out_last_reg <= out_last_next;
    end

`include "led_marquee_scroll_rotate_assert.svh"

    `LMSR_ASSERT_SAME(a_last_col, clk, rst_n, m_tvalid && m_tlast, m_tdata[4:0] == lmsr_pkg::LAST_COL, "frame end not on last column")
    `LMSR_ASSERT_NEXT(a_boundary_emit, clk, rst_n, in_accept && boundary, state_reg == ST_EMIT && col_reg == '0, "boundary tick did not start a frame")
    `LMSR_ASSERT_NEXT(a_tick_count, clk, rst_n, in_accept && !boundary, count_reg == $past(count_reg) + 1'b1, "tick count did not advance")
    `LMSR_ASSERT_NEXT(a_col_step, clk, rst_n, load, out_valid_reg && out_col_reg == $past(col_reg), "column not loaded in order")

endmodule
